>>> rtl/ttdr_pkg.sv
// ----------------------------------------------------------------------------
// ttdr_pkg
// Shared types and codes for the depth-preferred transposition table.
// ----------------------------------------------------------------------------
package ttdr_pkg;

  localparam int INDEX_BITS_DEF = 16;

  // action codes
  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic               action;
    logic [63:0]        position_key;
    logic [7:0]         search_depth;
    logic signed [15:0] eval_score;
    logic [1:0]         bound_kind;
    logic [15:0]        move_word;
  } ttdr_in_t;

  typedef struct packed {
    logic               written;
    logic               hit;
    logic [7:0]         found_depth;
    logic signed [15:0] found_score;
    logic [1:0]         found_kind;
    logic [7:0]         found_age;
    logic [15:0]        found_move;
    logic [31:0]        hit_total;
    logic [31:0]        lookup_total;
  } ttdr_out_t;

  // one slot of the entry memory
  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [1:0]         kind;
    logic [7:0]         age;
    logic [15:0]        move;
  } ttdr_entry_t;

  // write controls from the sequencer to the slot memories
  typedef struct packed {
    logic vld_we;
    logic ent_we;
    logic vld_bit;
  } ttdr_wr_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ttdr_state_t;

endpackage

>>> rtl/ttdr_slot_mem.sv
// ----------------------------------------------------------------------------
// ttdr_slot_mem
// Valid-mark memory and entry memory, one write and one read port each,
// read data registered.
// ----------------------------------------------------------------------------
module ttdr_slot_mem
  import ttdr_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  ttdr_wr_ctl_t          wr_ctl,
  input  logic [INDEX_BITS-1:0] wr_addr,
  input  ttdr_entry_t           wr_entry,
  input  logic [INDEX_BITS-1:0] rd_addr,
  output logic                  rd_vld,
  output ttdr_entry_t           rd_entry
);

  localparam int Depth = 1 << INDEX_BITS;

  logic        vld_mem [Depth];
  ttdr_entry_t ent_mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_ctl.vld_we) begin
      vld_mem[wr_addr] <= wr_ctl.vld_bit;
    end
    rd_vld <= vld_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.ent_we) begin
      ent_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= ent_mem[rd_addr];
  end

endmodule

>>> rtl/ttdr_ctrl.sv
// ----------------------------------------------------------------------------
// ttdr_ctrl
// Sequencer: clearing pass, slot read-modify-write, counters and result
// register.
// ----------------------------------------------------------------------------
module ttdr_ctrl
  import ttdr_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ttdr_in_t              request,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  rd_vld,
  input  ttdr_entry_t           rd_entry,
  output ttdr_wr_ctl_t          wr_ctl,
  output logic [INDEX_BITS-1:0] wr_addr,
  output ttdr_entry_t           wr_entry,
  output logic                  done,
  output ttdr_out_t             result
);

  ttdr_state_t           state;
  ttdr_state_t           state_next;
  logic [INDEX_BITS-1:0] clr_addr;
  logic [7:0]            search_gen;
  ttdr_in_t              req;
  logic [31:0]           hit_cnt;
  logic [31:0]           lookup_cnt;
  logic [31:0]           hit_cnt_next;
  logic [31:0]           lookup_cnt_next;
  logic                  accept;
  logic                  is_lookup;
  logic                  refuse;
  logic                  hit_now;
  ttdr_out_t             result_next;

  assign accept    = start && !busy;
  assign is_lookup = (req.action == ACT_LOOKUP);
  assign refuse    = rd_vld && (rd_entry.depth > req.search_depth);
  assign hit_now   = is_lookup && rd_vld && (rd_entry.key == req.position_key);

  assign wr_entry = '{key:   req.position_key,
                      depth: req.search_depth,
                      score: req.eval_score,
                      kind:  req.bound_kind,
                      age:   search_gen,
                      move:  req.move_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    wr_ctl     = '{vld_we: 1'b0, ent_we: 1'b0, vld_bit: 1'b0};
    wr_addr    = req.position_key[INDEX_BITS-1:0];
    case (state)
      ST_CLEAR: begin
        wr_ctl.vld_we = 1'b1;
        wr_addr       = clr_addr;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // slot data arrived; write back on an accepted store
        if (!is_lookup && !refuse) begin
          wr_ctl = '{vld_we: 1'b1, ent_we: 1'b1, vld_bit: 1'b1};
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    hit_cnt_next    = hit_cnt + 32'(hit_now);
    lookup_cnt_next = lookup_cnt + 32'(is_lookup);
    result_next     = '0;
    result_next.written      = !is_lookup && !refuse;
    result_next.hit          = hit_now;
    result_next.hit_total    = hit_cnt_next;
    result_next.lookup_total = lookup_cnt_next;
    if (hit_now) begin
      result_next.found_depth = rd_entry.depth;
      result_next.found_score = rd_entry.score;
      result_next.found_kind  = rd_entry.kind;
      result_next.found_age   = rd_entry.age;
      result_next.found_move  = rd_entry.move;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      search_gen  <= '0;
      hit_cnt     <= '0;
      lookup_cnt  <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        search_gen <= cfg_wdata;
      end
      if (state == ST_EXEC) begin
        hit_cnt    <= hit_cnt_next;
        lookup_cnt <= lookup_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    if (state == ST_EXEC) begin
      result <= result_next;
    end
  end

  a_done_after_exec : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result strobe without a slot access");

  a_store_or_hit : assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.written && result.hit))
    else $error("store and hit reported together");

  a_store_keeps_counts : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && !is_lookup |=>
      (hit_cnt == $past(hit_cnt)) && (lookup_cnt == $past(lookup_cnt)))
    else $error("counters moved on a store");

  a_miss_zero_fields : assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> (result.found_depth == '0) && (result.found_move == '0)
      && (result.found_age == '0))
    else $error("found fields set without a hit");

endmodule

>>> rtl/transposition_table_depth_replace_top.sv
// ----------------------------------------------------------------------------
// transposition_table_depth_replace_top
// Direct-mapped transposition table with depth-preferred replacement.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 2^INDEX_BITS valid
// marks (65536 at the default), with busy high throughout. For each item the
// slot is read on the accept edge and the read-modify-write of the slot
// memories happens in the next cycle, with busy high. The result is registered
// at the end of that cycle and shown with done high for exactly one cycle;
// the receiver cannot stall it, and the next item may be accepted while done
// is high.
module transposition_table_depth_replace_top
  import ttdr_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ttdr_in_t  request,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic      done,
  output ttdr_out_t result
);

  ttdr_wr_ctl_t          wr_ctl;
  logic [INDEX_BITS-1:0] wr_addr;
  ttdr_entry_t           wr_entry;
  logic                  rd_vld;
  ttdr_entry_t           rd_entry;

  ttdr_slot_mem #(
    .INDEX_BITS(INDEX_BITS)
  ) u_mem (
    .clk      (clk),
    .wr_ctl   (wr_ctl),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (request.position_key[INDEX_BITS-1:0]),
    .rd_vld   (rd_vld),
    .rd_entry (rd_entry)
  );

  ttdr_ctrl #(
    .INDEX_BITS(INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_vld    (rd_vld),
    .rd_entry  (rd_entry),
    .wr_ctl    (wr_ctl),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .done      (done),
    .result    (result)
  );

endmodule

>>> bench/ttdr_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttdr_table_checker
// Watches the request, result and age channels of the transposition table,
// keeps its own copy of the slots and counters, and compares every result
// field by field with the outcome predicted for the oldest open item.
// ----------------------------------------------------------------------------
module ttdr_table_checker
  import ttdr_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  ttdr_in_t   request,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       done,
  input  ttdr_out_t  result,
  output int         fail_count,
  output int         outstanding
);

  // a slot is valid exactly when it has an entry here
  ttdr_entry_t slot_mem [int];
  ttdr_out_t   outcome_q [$];
  logic [31:0] hits_seen;
  logic [31:0] lookups_seen;
  logic [7:0]  age_now;
  int          mismatch_n = 0;

  assign fail_count = mismatch_n;

  function automatic ttdr_out_t table_access(input ttdr_in_t req);
    ttdr_out_t   r;
    ttdr_entry_t ent;
    int          idx;
    r   = '0;
    idx = int'(req.position_key[INDEX_BITS-1:0]);
    if (req.action == ACT_STORE) begin
      // refuse only when a deeper entry already sits in the slot
      if (!(slot_mem.exists(idx) && slot_mem[idx].depth > req.search_depth)) begin
        ent.key   = req.position_key;
        ent.depth = req.search_depth;
        ent.score = req.eval_score;
        ent.kind  = req.bound_kind;
        ent.age   = age_now;
        ent.move  = req.move_word;
        slot_mem[idx] = ent;
        r.written = 1'b1;
      end
    end else begin
      lookups_seen = lookups_seen + 32'd1;
      if (slot_mem.exists(idx) && slot_mem[idx].key == req.position_key) begin
        hits_seen     = hits_seen + 32'd1;
        r.hit         = 1'b1;
        r.found_depth = slot_mem[idx].depth;
        r.found_score = slot_mem[idx].score;
        r.found_kind  = slot_mem[idx].kind;
        r.found_age   = slot_mem[idx].age;
        r.found_move  = slot_mem[idx].move;
      end
    end
    r.hit_total    = hits_seen;
    r.lookup_total = lookups_seen;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_n++;
    end
  endfunction

  always @(posedge clk) begin : watch
    ttdr_out_t want;
    if (rst) begin
      slot_mem.delete();
      outcome_q.delete();
      hits_seen    = '0;
      lookups_seen = '0;
      age_now      = '0;
    end else begin
      if (cfg_we) begin
        age_now = cfg_wdata;
      end
      // retire the oldest item before taking a new one on the same edge
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no item outstanding");
          mismatch_n++;
        end else begin
          want = outcome_q.pop_front();
          check_field("written",      want.written,      result.written);
          check_field("hit",          want.hit,          result.hit);
          check_field("found_depth",  want.found_depth,  result.found_depth);
          check_field("found_score",  want.found_score,  result.found_score);
          check_field("found_kind",   want.found_kind,   result.found_kind);
          check_field("found_age",    want.found_age,    result.found_age);
          check_field("found_move",   want.found_move,   result.found_move);
          check_field("hit_total",    want.hit_total,    result.hit_total);
          check_field("lookup_total", want.lookup_total, result.lookup_total);
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(table_access(request));
      end
    end
    outstanding <= outcome_q.size();
  end

endmodule

>>> bench/transposition_table_depth_replace_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transposition_table_depth_replace_top_tb
// Drives store and lookup items into the transposition table through several
// age settings: a directed run over edge keys, depths and replacement cases,
// then random items over a small set of colliding keys with random gaps.
// ----------------------------------------------------------------------------
module transposition_table_depth_replace_top_tb;
  import ttdr_pkg::*;

  localparam int INDEX_W        = INDEX_BITS_DEF;
  localparam int POOL_N         = 16;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 220;
  localparam int WATCHDOG_LIMIT = 300000;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  ttdr_in_t   request;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       done;
  ttdr_out_t  result;
  int         fail_count;
  int         outstanding;
  int         idle_cycles = 0;

  logic [63:0] key_pool [POOL_N];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  transposition_table_depth_replace_top #(
    .INDEX_BITS(INDEX_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .result   (result)
  );

  ttdr_table_checker #(
    .INDEX_BITS(INDEX_W)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // give up after a long stretch with no item in or out; covers the clearing pass
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("transposition_table_depth_replace_top verification failed");
      $finish;
    end
  end

  function automatic ttdr_in_t probe(input logic act, input logic [63:0] key,
                                     input logic [7:0] depth, input logic [15:0] score,
                                     input logic [1:0] kind, input logic [15:0] mv);
    ttdr_in_t it;
    it.action       = act;
    it.position_key = key;
    it.search_depth = depth;
    it.eval_score   = score;
    it.bound_kind   = kind;
    it.move_word    = mv;
    return it;
  endfunction

  function automatic ttdr_in_t random_probe();
    int unsigned roll;
    logic [7:0]  depth;
    logic [63:0] key;
    roll = $urandom_range(0, 99);
    // a few keys land on arbitrary slots; the rest hit the colliding pool
    if (roll < 10) begin
      key = {$urandom, $urandom};
    end else begin
      key = key_pool[$urandom_range(0, POOL_N - 1)];
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      depth = 8'($urandom_range(0, 7));
    end else if (roll < 78) begin
      depth = 8'h00;
    end else if (roll < 86) begin
      depth = 8'hFF;
    end else begin
      depth = 8'($urandom);
    end
    return probe($urandom_range(0, 1) ? ACT_LOOKUP : ACT_STORE, key, depth,
                 16'($urandom), 2'($urandom_range(0, 3)), 16'($urandom));
  endfunction

  // pairs of keys share a slot but differ above the index bits
  task automatic refresh_pool();
    for (int i = 0; i < POOL_N; i += 2) begin
      key_pool[i]     = {$urandom, $urandom};
      key_pool[i + 1] = {$urandom, $urandom};
      key_pool[i + 1][INDEX_W-1:0] = key_pool[i][INDEX_W-1:0];
    end
  endtask

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    if (quiet) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  task automatic issue(input ttdr_in_t it, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_age(input logic [7:0] age);
    cfg_wdata <= age;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [63:0] ones_key;
    logic [63:0] alias_zero;
    logic [63:0] alias_ones;
    ttdr_in_t    plan [$];
    logic [7:0]  age;
    ones_key   = '1;
    alias_zero = {48'hFFFF_FFFF_FFFF, 16'h0000};
    alias_ones = {48'h0000_0000_0000, 16'hFFFF};
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_age(8'hFF);

    // empty slot, extreme fields, collisions, equal, lesser and greater depths
    plan.push_back(probe(ACT_LOOKUP, 64'd0, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_STORE, 64'd0, 8'd0, 16'h8000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_LOOKUP, 64'd0, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_STORE, ones_key, 8'hFF, 16'h7FFF, 2'd3, 16'hFFFF));
    plan.push_back(probe(ACT_LOOKUP, ones_key, 8'hFF, 16'hFFFF, 2'd3, 16'hFFFF));
    plan.push_back(probe(ACT_STORE, alias_zero, 8'd0, 16'h1234, 2'd1, 16'hA5A5));
    plan.push_back(probe(ACT_LOOKUP, 64'd0, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_LOOKUP, alias_zero, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_STORE, ones_key, 8'hFE, 16'h0001, 2'd2, 16'h5A5A));
    plan.push_back(probe(ACT_LOOKUP, ones_key, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_STORE, alias_ones, 8'hFF, 16'hFFFF, 2'd2, 16'h0001));
    plan.push_back(probe(ACT_LOOKUP, ones_key, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_LOOKUP, alias_ones, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_STORE, 64'd0, 8'd10, 16'hFF00, 2'd1, 16'h00FF));
    plan.push_back(probe(ACT_STORE, 64'd0, 8'd11, 16'h00FF, 2'd2, 16'hFF00));
    plan.push_back(probe(ACT_STORE, 64'd0, 8'd10, 16'h4321, 2'd3, 16'h1111));
    plan.push_back(probe(ACT_LOOKUP, 64'd0, 8'd0, 16'h0000, 2'd0, 16'h0000));
    plan.push_back(probe(ACT_LOOKUP, 64'h8000_0000_0000_1234, 8'd0, 16'h0000, 2'd0,
                         16'h0000));
    foreach (plan[i]) begin
      issue(plan[i], pick_gap(1'b0));
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      age = (p == 0) ? 8'h00 : (p == 3) ? 8'h80 : 8'($urandom);
      set_age(age);
      refresh_pool();
      // one phase runs back to back with no idling at all
      repeat (PHASE_ITEMS) issue(random_probe(), pick_gap(p == 2));
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("transposition_table_depth_replace_top verification clean");
    end else begin
      $display("transposition_table_depth_replace_top verification failed");
    end
    $finish;
  end

endmodule

>>> transposition_table_depth_replace_top.f
rtl/ttdr_pkg.sv
rtl/ttdr_slot_mem.sv
rtl/ttdr_ctrl.sv
rtl/transposition_table_depth_replace_top.sv
bench/ttdr_table_checker.sv
bench/transposition_table_depth_replace_top_tb.sv
